// ----- rtl/mosu_pkg.sv -----
// Shared types and constants for the median of sample set unit.
// Holds the request and response word layouts and the control phase type.
// No dependencies.
package mosu_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MEDIAN_W    = 17;
   localparam int SET_COUNT_W = 6;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
   } req_word_type;

   typedef struct packed {
      logic [MEDIAN_W-1:0]    median_twice;
      logic [SET_COUNT_W-1:0] set_count;
      logic                   overflow;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic held;
   } cell_ctl_type;

   typedef enum logic {
      PH_COLLECT,
      PH_FINISH
   } phase_type;

endpackage

// ----- rtl/mosu_cell.sv -----
// One cell of the sorted insertion chain of the median of sample set unit.
// Depends on mosu_pkg for the cell control struct.
module mosu_cell #(
   parameter int VAL_W = 16
) (
   input  logic                  clock,
   input  mosu_pkg::cell_ctl_type ctl,
   input  logic [VAL_W-1:0]      new_value,
   input  logic                  prev_keep,
   input  logic [VAL_W-1:0]      prev_data,
   output logic                  keep,
   output logic [VAL_W-1:0]      data
);

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;

   // A held value no greater than the new one stays; otherwise the cell takes
   // the new value at the insertion point or the value of its lower neighbor.
   assign keep = ctl.held && (data_ff <= new_value);

   always_comb begin
      if (keep) begin
         data_in = data_ff;
      end else if (prev_keep) begin
         data_in = new_value;
      end else begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// ----- rtl/median_of_sample_set_unit.sv -----
// Median of a sample set: a sorted insertion chain with a registered result.
// Depends on mosu_pkg and instantiates one mosu_cell per stored sample.
//
// Samples enter one per cycle while req_stall is low and are inserted in
// ascending order by a row of MAX_SAMPLES cells, each comparing its value
// with the incoming sample and shifting toward its neighbor in the same
// cycle. When a word marked as the last sample is accepted, the next cycle
// reads the two middle cells, adds them and loads the result register;
// during that cycle req_stall is high. That finishing cycle waits further
// only while an earlier result is still held in the output register under
// rsp_stall. Samples beyond MAX_SAMPLES are dropped and flagged in the result.
module median_of_sample_set_unit #(
   parameter int MAX_SAMPLES = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mosu_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mosu_pkg::rsp_word_type rsp_word
);

   localparam int VAL_W = (SAMPLE_BITS < mosu_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                             : mosu_pkg::SAMPLE_W;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   mosu_pkg::phase_type phase_ff;
   mosu_pkg::phase_type phase_in;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             drop_ff;
   logic             drop_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   mosu_pkg::rsp_word_type rsp_word_ff;
   mosu_pkg::rsp_word_type rsp_word_in;

   logic             accept;
   logic             room;
   logic             load;
   logic             slot_free;
   logic             finish_take;
   logic [VAL_W-1:0] new_value;

   logic [CNT_W-1:0] half_idx;
   logic [CNT_W-1:0] lo_idx;
   logic [VAL_W-1:0] lo_val;
   logic [VAL_W-1:0] hi_val;
   logic [VAL_W:0]   pair_sum;

   logic [MAX_SAMPLES-1:0] keep;
   logic [VAL_W-1:0]       cell_data [MAX_SAMPLES];
   logic [VAL_W-1:0]       lo_part   [MAX_SAMPLES];
   logic [VAL_W-1:0]       hi_part   [MAX_SAMPLES];

   assign new_value = VAL_W'(req_word.sample);
   assign accept    = req_valid && !req_stall;
   assign room      = (count_ff != CNT_W'(MAX_SAMPLES));
   assign load      = accept && room;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      mosu_pkg::cell_ctl_type ctl;
      logic                   prev_keep;
      logic [VAL_W-1:0]       prev_data;

      assign ctl.load = load;
      assign ctl.held = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_keep = 1'b1;
         assign prev_data = new_value;
      end else begin : g_body
         assign prev_keep = keep[i-1];
         assign prev_data = cell_data[i-1];
      end

      mosu_cell #(
         .VAL_W(VAL_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .new_value(new_value),
         .prev_keep(prev_keep),
         .prev_data(prev_data),
         .keep     (keep[i]),
         .data     (cell_data[i])
      );

      assign lo_part[i] = cell_data[i] & {VAL_W{CNT_W'(i) == lo_idx}};
      assign hi_part[i] = cell_data[i] & {VAL_W{CNT_W'(i) == half_idx}};
   end

   assign half_idx = count_ff >> 1;
   assign lo_idx   = count_ff[0] ? half_idx : (half_idx - CNT_W'(1));

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         lo_val = lo_val | lo_part[i];
         hi_val = hi_val | hi_part[i];
      end
   end

   assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};

   always_comb begin
      case (phase_ff)
         mosu_pkg::PH_COLLECT: begin
            phase_in = (accept && req_word.last_sample) ? mosu_pkg::PH_FINISH
                                                        : mosu_pkg::PH_COLLECT;
         end
         mosu_pkg::PH_FINISH: begin
            phase_in = slot_free ? mosu_pkg::PH_COLLECT : mosu_pkg::PH_FINISH;
         end
         default: begin
            phase_in = mosu_pkg::PH_COLLECT;
         end
      endcase
   end

   always_comb begin
      case (phase_ff)
         mosu_pkg::PH_COLLECT: begin
            req_stall   = 1'b0;
            finish_take = 1'b0;
         end
         mosu_pkg::PH_FINISH: begin
            req_stall   = 1'b1;
            finish_take = slot_free;
         end
         default: begin
            req_stall   = 1'b1;
            finish_take = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (finish_take) begin
         count_in = '0;
         drop_in  = 1'b0;
      end else if (load) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept) begin
         drop_in = 1'b1;
      end
   end

   assign rsp_valid_in = finish_take || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_word_in.median_twice = mosu_pkg::MEDIAN_W'(pair_sum);
      rsp_word_in.set_count    = mosu_pkg::SET_COUNT_W'(count_ff);
      rsp_word_in.overflow     = drop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mosu_pkg::PH_COLLECT;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("Held sample count exceeds the chain length.");

   a_finish_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mosu_pkg::PH_FINISH |-> count_ff != '0)
      else $error("Finishing a set with no held samples.");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      finish_take |=> (count_ff == '0) && !drop_ff && rsp_valid_ff)
      else $error("Set state not cleared after the result was loaded.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff == mosu_pkg::PH_FINISH))
      else $error("Result appeared without a finishing cycle.");

   if (MAX_SAMPLES > 1) begin : g_order_chk
      a_head_sorted: assert property (@(posedge clock) disable iff (reset)
         count_ff >= CNT_W'(2) |-> cell_data[0] <= cell_data[1])
         else $error("Chain head is out of order.");
   end
`endif

endmodule
